// ===== sv/half_float_converter_core_macros.svh =====
// Assertion macros for the half float converter
`ifndef HALF_FLOAT_CONVERTER_CORE_MACROS_SVH
`define HALF_FLOAT_CONVERTER_CORE_MACROS_SVH
// Check a property on every clock edge outside reset
`define HFC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check an implication in the following cycle
`define HFC_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`endif

// ===== sv/hfc_pkg.sv =====
// Package with shared types and constants for the half float converter
`default_nettype none
package hfc_pkg;
  localparam logic CmdS2h = 1'b0;
  localparam logic CmdH2s = 1'b1;

  // Decoded operand, passed from decode to compute stage
  typedef struct packed {
    logic        cmd;
    logic        sign;
    logic [30:0] mag;
    logic        s_zero;   // single exp zero
    logic        s_small;  // below smallest half normal
    logic        s_ovf;    // finite, above largest half normal
    logic        s_inf;
    logic        s_nan_lo; // nan whose payload vanishes
    logic        s_nan;
    logic [4:0]  sh;       // subnormal shift minus 14
    logic        sh_big;
    logic        h_zero;
    logic        h_sub;
    logic        h_max;
  } dec_t;
endpackage
`default_nettype wire

// ===== sv/hfc_decode.sv =====
// Decode stage: classify the operand
`default_nettype none
module hfc_decode (
  input  wire logic          cmd_i,
  input  wire logic [31:0]   op_i,
  output hfc_pkg::dec_t      dec_o
);
  logic [30:0] mag;
  logic [7:0]  e;
  logic [7:0]  shf;
  // Classify both directions at once
  always_comb begin
    if (cmd_i == hfc_pkg::CmdS2h) begin
      mag = op_i[30:0];
      dec_o.sign = op_i[31];
    end else begin
      mag = {16'd0, op_i[14:0]};
      dec_o.sign = op_i[15];
    end
    e = mag[30:23];
    shf = 8'd112 - e;
    dec_o.cmd = cmd_i;
    dec_o.mag = mag;
    dec_o.s_zero = (e == 8'd0);
    dec_o.s_small = (mag < 31'h38800000);
    dec_o.s_ovf = (mag > 31'h477FE000) && (mag < 31'h7F800000);
    dec_o.s_inf = (mag == 31'h7F800000);
    dec_o.s_nan_lo = (mag > 31'h7F800000) && (mag < 31'h7F802000);
    dec_o.s_nan = (mag >= 31'h7F802000);
    dec_o.sh = shf[4:0];
    dec_o.sh_big = (shf >= 8'd10);
    dec_o.h_zero = (mag[14:0] == 15'd0);
    dec_o.h_sub = (mag[14:10] == 5'd0);
    dec_o.h_max = (mag[14:10] == 5'h1F);
  end
endmodule
`default_nettype wire

// ===== sv/hfc_compute.sv =====
// Compute stage: form half or single result from decoded operand
`default_nettype none
module hfc_compute (
  input  wire hfc_pkg::dec_t dec_i,
  output logic [31:0]        res_o
);
  logic [23:0] m;
  logic [15:0] h;
  logic [3:0]  p;
  logic [9:0]  hm;
  logic [22:0] frac;
  // Build the result for the selected direction
  always_comb begin
    m = {1'b1, dec_i.mag[22:0]};
    hm = dec_i.mag[9:0];
    p = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (hm[i]) p = 4'(i);
    end
    frac = 23'({13'd0, hm} << (5'd23 - {1'b0, p}));
    if (dec_i.s_zero) h = 16'd0;
    else if (dec_i.s_small) h = dec_i.sh_big ? 16'd0 : 16'(m >> (5'd14 + dec_i.sh));
    else if (dec_i.s_ovf || dec_i.s_inf) h = 16'h7C00;
    else if (dec_i.s_nan_lo) h = 16'h7C01;
    else if (dec_i.s_nan) h = {6'b011111, dec_i.mag[22:13]};
    else h = 16'(dec_i.mag[30:13] - 18'h1C000);
    if (dec_i.cmd == hfc_pkg::CmdS2h) begin
      res_o = {16'd0, dec_i.sign, h[14:0]};
    end else if (dec_i.h_zero) begin
      res_o = {dec_i.sign, 31'd0};
    end else if (dec_i.h_sub) begin
      res_o = {dec_i.sign, 8'(p) + 8'd103, frac};
    end else if (dec_i.h_max) begin
      res_o = {dec_i.sign, 8'hFF, hm, 13'd0};
    end else begin
      res_o = {dec_i.sign, 8'({3'd0, dec_i.mag[14:10]}) + 8'd112, hm, 13'd0};
    end
  end
endmodule
`default_nettype wire

// ===== sv/half_float_converter_core.sv =====
// Top level of the half float converter: three-stage pipeline
// Channel | Ports                      | Beat
// in      | start_i, command_i, operand_bits_i | start_i && !busy_o
// out     | done_o, result_bits_o      | done_o, one cycle
// A beat enters every cycle.
// Latency is set by the input, decode and compute registers.
// Reset clears the valid bits only; busy_o is always low.
// The receiver cannot stall, so nothing is held back.
`default_nettype none
`include "half_float_converter_core_macros.svh"
module half_float_converter_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic        command_i,
  input  wire logic [31:0] operand_bits_i,
  output logic             done_o,
  output logic [31:0]      result_bits_o
);
  logic v0_q, v1_q, v2_q;
  logic c0_q;
  logic [31:0] o0_q;
  hfc_pkg::dec_t dec_d, dec_q;
  logic [31:0] res_d, res_q;

  assign busy_o = 1'b0;

  hfc_decode u_dec (.cmd_i(c0_q), .op_i(o0_q), .dec_o(dec_d));
  hfc_compute u_cmp (.dec_i(dec_q), .res_o(res_d));

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0; v1_q <= 1'b0; v2_q <= 1'b0;
    end else begin
      v0_q <= start_i; v1_q <= v0_q; v2_q <= v1_q;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    c0_q <= command_i;
    o0_q <= operand_bits_i;
    dec_q <= dec_d;
    res_q <= res_d;
  end

  assign done_o = v2_q;
  assign result_bits_o = res_q;

  `HFC_ASSERT_NEXT(a_pipe, start_i, v0_q, "beat lost at entry")
  `HFC_ASSERT_NEXT(a_out, v1_q, done_o, "beat lost at output")
  `HFC_ASSERT(a_half_hi, !(done_o && !$past(dec_q.cmd) && result_bits_o[31:16] != 16'd0),
    "half result upper bits set")
endmodule
`default_nettype wire
